### rtl/wvs_pkg.sv
// ----------------------------------------------------------------------------
// wvs_pkg
// Shared widths, types and constants of the weighted vector statistics core.
// ----------------------------------------------------------------------------
package wvs_pkg;

    localparam int LANES      = 4;
    localparam int LANE_W     = 2;
    localparam int DIMS_W     = 3;
    localparam int SAMPLE_W   = 32;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_W     = 48;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 64;
    localparam int TW_W       = 48;
    localparam int CNT_W      = 32;
    localparam int VAR_W      = 48;
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITERS  = SUM_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_ITERS + 1);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    // One accepted item after the front has formed its products
    typedef struct packed {
        logic                                clear;
        logic [WEIGHT_W-1:0]                 weight;
        logic [LANES-1:0][PROD_W-1:0]        prod;
        logic [LANES-1:0][SQ_W-1:0]          sq;
        logic [LANES-1:0][SAMPLE_W-1:0]      wval;
    } t_work;

    typedef struct packed {
        logic              cfg_clear;
        logic [DIMS_W-1:0] dims;
    } t_ctrl;

    typedef struct packed {
        logic count_zero;
    } t_status;

endpackage

### rtl/wvs_in_if.sv
// ----------------------------------------------------------------------------
// wvs_in_if
// Input channel: one sample vector with weight, or a clear request.
// ----------------------------------------------------------------------------
interface wvs_in_if;
    logic               valid;
    logic               ready;
    logic               clear_stats;
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic [15:0]        weight;

    modport source (output valid, clear_stats, sample_0, sample_1, sample_2, sample_3,
                    weight, input ready);
    modport sink   (input valid, clear_stats, sample_0, sample_1, sample_2, sample_3,
                    weight, output ready);
endinterface

### rtl/wvs_out_if.sv
// ----------------------------------------------------------------------------
// wvs_out_if
// Result channel: statistics of one component.
// ----------------------------------------------------------------------------
interface wvs_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         component;
    logic signed [31:0] mean;
    logic [47:0]        variance;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic               stats_valid;
    logic [31:0]        sample_total;
    logic               last_component;

    modport source (output valid, component, mean, variance, minimum, maximum,
                    stats_valid, sample_total, last_component, input ready);
    modport sink   (input valid, component, mean, variance, minimum, maximum,
                    stats_valid, sample_total, last_component, output ready);
endinterface

### rtl/wvs_front.sv
// ----------------------------------------------------------------------------
// wvs_front
// Accepts input beats and forms the per-lane products, one lane at a time.
// ----------------------------------------------------------------------------
module wvs_front
    import wvs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    wvs_in_if.sink i_in,
    output t_work  o_work,
    output logic   o_work_valid,
    input  logic   i_work_ready
);

    logic                       r_busy;
    logic                       r_done;
    logic                       r_phase;
    logic [LANE_W-1:0]          r_lane;
    logic [LANES-1:0][SAMPLE_W-1:0] r_s;
    logic [2*SAMPLE_W-1:0]      r_sqr;
    t_work                      r_work;

    logic signed [SAMPLE_W-1:0] w_s;
    logic signed [PROD_W:0]     w_p;
    logic [SAMPLE_W-1:0]        w_mag;
    logic signed [PROD_W-1:0]   w_pt;
    logic signed [PROD_W-9:0]   w_q;
    logic [SAMPLE_W-1:0]        w_val;
    logic [SQ_W-1:0]            w_sq;

    assign i_in.ready   = !r_busy;
    assign o_work       = r_work;
    assign o_work_valid = r_done;

    always_comb begin
        w_s   = $signed(r_s[r_lane]);
        w_p   = w_s * $signed({1'b0, r_work.weight});
        w_mag = w_s[SAMPLE_W-1] ? SAMPLE_W'(-w_s) : SAMPLE_W'(w_s);
        // round toward zero before the shift
        w_pt  = w_p[PROD_W-1] ? (w_p[PROD_W-1:0] + PROD_W'(255)) : w_p[PROD_W-1:0];
        w_q   = w_pt[PROD_W-1:8];
        if (w_q > $signed((PROD_W-8)'(32'h7FFFFFFF))) begin
            w_val = 32'h7FFFFFFF;
        end else if (w_q < -$signed((PROD_W-8)'(33'h80000000))) begin
            w_val = 32'h80000000;
        end else begin
            w_val = w_q[SAMPLE_W-1:0];
        end
        w_sq  = SQ_W'(r_sqr[2*SAMPLE_W-1:16] * r_work.weight);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_lane  <= '0;
        end else begin
            if (i_in.valid && !r_busy) begin
                r_busy       <= 1'b1;
                r_done       <= i_in.clear_stats;
                r_phase      <= 1'b0;
                r_lane       <= '0;
                r_work.clear <= i_in.clear_stats;
                r_work.weight <= i_in.weight;
                r_s          <= {i_in.sample_3, i_in.sample_2, i_in.sample_1, i_in.sample_0};
            end else if (r_busy && !r_done) begin
                if (!r_phase) begin
                    r_work.prod[r_lane] <= w_p[PROD_W-1:0];
                    r_work.wval[r_lane] <= w_val;
                    r_sqr               <= w_mag * w_mag;
                    r_phase             <= 1'b1;
                end else begin
                    r_work.sq[r_lane] <= w_sq;
                    r_phase           <= 1'b0;
                    if (r_lane == LANE_W'(LANES - 1)) begin
                        r_done <= 1'b1;
                    end else begin
                        r_lane <= r_lane + 1'b1;
                    end
                end
            end else if (r_done && i_work_ready) begin
                r_done <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

endmodule

### rtl/wvs_queue.sv
// ----------------------------------------------------------------------------
// wvs_queue
// Two-entry queue of work items between the front and the back.
// ----------------------------------------------------------------------------
module wvs_queue
    import wvs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_work i_work,
    input  logic  i_valid,
    output logic  o_ready,
    output t_work o_work,
    output logic  o_valid,
    input  logic  i_ready
);

    t_work             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_ready = r_cnt != QCNT_W'(QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_work  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

### rtl/wvs_div.sv
// ----------------------------------------------------------------------------
// wvs_div
// Dual restoring divider: two 64-bit dividends over one 48-bit divisor,
// DIV_STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
module wvs_div
    import wvs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_a,
    input  logic [SUM_W-1:0] i_b,
    input  logic [TW_W-1:0]  i_d,
    output logic             o_done,
    output logic [SUM_W-1:0] o_qa,
    output logic [SUM_W-1:0] o_qb
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [TW_W-1:0]      r_d;
    logic [TW_W-1:0]      r_rem_a;
    logic [TW_W-1:0]      r_rem_b;
    logic [SUM_W-1:0]     r_sh_a;
    logic [SUM_W-1:0]     r_sh_b;
    logic [TW_W-1:0]      n_rem_a;
    logic [TW_W-1:0]      n_rem_b;
    logic [SUM_W-1:0]     n_sh_a;
    logic [SUM_W-1:0]     n_sh_b;

    assign o_done = r_done;
    assign o_qa   = r_sh_a;
    assign o_qb   = r_sh_b;

    always_comb begin
        logic [TW_W:0] t_a;
        logic [TW_W:0] t_b;
        n_rem_a = r_rem_a;
        n_rem_b = r_rem_b;
        n_sh_a  = r_sh_a;
        n_sh_b  = r_sh_b;
        for (int k = 0; k < DIV_STEP; k++) begin
            t_a    = {n_rem_a, n_sh_a[SUM_W-1]};
            t_b    = {n_rem_b, n_sh_b[SUM_W-1]};
            n_sh_a = {n_sh_a[SUM_W-2:0], 1'b0};
            n_sh_b = {n_sh_b[SUM_W-2:0], 1'b0};
            if (t_a >= {1'b0, r_d}) begin
                t_a       = t_a - {1'b0, r_d};
                n_sh_a[0] = 1'b1;
            end
            if (t_b >= {1'b0, r_d}) begin
                t_b       = t_b - {1'b0, r_d};
                n_sh_b[0] = 1'b1;
            end
            n_rem_a = t_a[TW_W-1:0];
            n_rem_b = t_b[TW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt   <= DIV_CNT_W'(DIV_ITERS);
                r_d     <= i_d;
                r_rem_a <= '0;
                r_rem_b <= '0;
                r_sh_a  <= i_a;
                r_sh_b  <= i_b;
            end else if (r_cnt != '0) begin
                r_cnt   <= r_cnt - 1'b1;
                r_rem_a <= n_rem_a;
                r_rem_b <= n_rem_b;
                r_sh_a  <= n_sh_a;
                r_sh_b  <= n_sh_b;
                if (r_cnt == DIV_CNT_W'(1)) r_done <= 1'b1;
            end
        end
    end

endmodule

### rtl/wvs_back.sv
// ----------------------------------------------------------------------------
// wvs_back
// Updates the accumulators and produces one result beat per active component.
// ----------------------------------------------------------------------------
module wvs_back
    import wvs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl      i_ctrl,
    output t_status    o_status,
    input  t_work      i_work,
    input  logic       i_work_valid,
    output logic       o_work_ready,
    wvs_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_VAR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                  r_state;
    logic [LANE_W-1:0]           r_lane;
    t_work                       r_work;
    logic [LANES-1:0][SUM_W-1:0] r_ws;
    logic [LANES-1:0][SUM_W-1:0] r_wss;
    logic [LANES-1:0][SAMPLE_W-1:0] r_min;
    logic [LANES-1:0][SAMPLE_W-1:0] r_max;
    logic [TW_W-1:0]             r_tw;
    logic [CNT_W-1:0]            r_count;
    logic signed [SAMPLE_W-1:0]  r_mean;
    logic [SUM_W-1:0]            r_e2;
    logic [SUM_W-1:0]            r_msq;

    logic             r_ov;
    logic [1:0]       r_comp;
    logic [31:0]      r_omean;
    logic [VAR_W-1:0] r_ovar;
    logic [31:0]      r_omin;
    logic [31:0]      r_omax;
    logic             r_ostv;
    logic [31:0]      r_ototal;
    logic             r_olast;

    logic             w_start;
    logic             w_div_done;
    logic [SUM_W-1:0] w_qa;
    logic [SUM_W-1:0] w_qb;
    logic [SUM_W-1:0] w_mag;
    logic             w_neg;
    logic             w_last;
    logic [SUM_W-1:0] w_msq_s;
    logic [SUM_W-1:0] w_var;
    logic [TW_W:0]    w_tw_sum;

    assign o_work_ready       = r_state == S_IDLE;
    assign o_status.count_zero = r_count == '0;

    assign o_out.valid          = r_ov;
    assign o_out.component      = r_comp;
    assign o_out.mean           = r_omean;
    assign o_out.variance       = r_ovar;
    assign o_out.minimum        = r_omin;
    assign o_out.maximum        = r_omax;
    assign o_out.stats_valid    = r_ostv;
    assign o_out.sample_total   = r_ototal;
    assign o_out.last_component = r_olast;

    assign w_neg    = r_ws[r_lane][SUM_W-1];
    assign w_mag    = w_neg ? (~r_ws[r_lane] + 1'b1) : r_ws[r_lane];
    assign w_start  = (r_state == S_START) && (r_tw != '0);
    assign w_last   = {1'b0, r_lane} == DIMS_W'(i_ctrl.dims - 1'b1);
    assign w_msq_s  = r_msq >> 16;
    assign w_var    = (r_e2 > w_msq_s) ? (r_e2 - w_msq_s) : '0;
    assign w_tw_sum = {1'b0, r_tw} + (TW_W+1)'(r_work.weight);

    wvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (w_mag),
        .i_b     (r_wss[r_lane]),
        .i_d     (r_tw),
        .o_done  (w_div_done),
        .o_qa    (w_qa),
        .o_qb    (w_qb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lane  <= '0;
            r_ov    <= 1'b0;
            r_tw    <= '0;
            r_count <= '0;
            for (int i = 0; i < LANES; i++) begin
                r_ws[i]  <= '0;
                r_wss[i] <= '0;
                r_min[i] <= 32'h7FFFFFFF;
                r_max[i] <= 32'h80000000;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctrl.cfg_clear || (i_work_valid && i_work.clear)) begin
                        r_tw    <= '0;
                        r_count <= '0;
                        for (int i = 0; i < LANES; i++) begin
                            r_ws[i]  <= '0;
                            r_wss[i] <= '0;
                            r_min[i] <= 32'h7FFFFFFF;
                            r_max[i] <= 32'h80000000;
                        end
                    end else if (i_work_valid) begin
                        r_work  <= i_work;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    for (int i = 0; i < LANES; i++) begin
                        logic signed [SUM_W:0] t_s;
                        logic [SUM_W:0]        t_q;
                        t_s = $signed({r_ws[i][SUM_W-1], r_ws[i]})
                            + (SUM_W+1)'($signed(r_work.prod[i]));
                        t_q = {1'b0, r_wss[i]} + (SUM_W+1)'(r_work.sq[i]);
                        if (DIMS_W'(i) < i_ctrl.dims) begin
                            if (t_s[SUM_W] != t_s[SUM_W-1]) begin
                                r_ws[i] <= t_s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                      : {1'b0, {(SUM_W-1){1'b1}}};
                            end else begin
                                r_ws[i] <= t_s[SUM_W-1:0];
                            end
                            r_wss[i] <= t_q[SUM_W] ? '1 : t_q[SUM_W-1:0];
                            if ($signed(r_work.wval[i]) < $signed(r_min[i]))
                                r_min[i] <= r_work.wval[i];
                            if ($signed(r_work.wval[i]) > $signed(r_max[i]))
                                r_max[i] <= r_work.wval[i];
                        end
                    end
                    r_tw    <= w_tw_sum[TW_W] ? '1 : w_tw_sum[TW_W-1:0];
                    r_count <= (r_count == '1) ? r_count : r_count + 1'b1;
                    r_lane  <= '0;
                    r_state <= S_START;
                end
                S_START: begin
                    if (r_tw == '0) begin
                        // no weight yet: mean and variance read as zero
                        r_ov     <= 1'b1;
                        r_comp   <= r_lane;
                        r_omean  <= '0;
                        r_ovar   <= '0;
                        r_omin   <= r_min[r_lane];
                        r_omax   <= r_max[r_lane];
                        r_ostv   <= 1'b0;
                        r_ototal <= r_count;
                        r_olast  <= w_last;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (w_neg) begin
                            r_mean <= (w_qa > SUM_W'(33'h80000000)) ? 32'h80000000
                                                                   : 32'(~w_qa + 1'b1);
                        end else begin
                            r_mean <= (w_qa > SUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                   : w_qa[31:0];
                        end
                        r_e2    <= w_qb;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_msq   <= SUM_W'(r_mean * r_mean);
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_ov     <= 1'b1;
                    r_comp   <= r_lane;
                    r_omean  <= r_mean;
                    r_ovar   <= (w_var[SUM_W-1:VAR_W] != '0) ? '1 : w_var[VAR_W-1:0];
                    r_omin   <= r_min[r_lane];
                    r_omax   <= r_max[r_lane];
                    r_ostv   <= 1'b1;
                    r_ototal <= r_count;
                    r_olast  <= w_last;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ov <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_lane  <= r_lane + 1'b1;
                            r_state <= S_START;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_tw != '0)
        else $error("division started with zero total weight");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.last_component |=> r_state == S_IDLE)
        else $error("back did not return to idle after last component");
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside its wait state");
    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_state == S_OUT)
        else $error("result beat shown outside output state");
`endif

endmodule

### rtl/weighted_vector_statistics_core.sv
// ----------------------------------------------------------------------------
// weighted_vector_statistics_core
// Weighted running mean, variance, minimum and maximum over up to four lanes.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat
// i_in      in   clear request, or four Q16.16 samples and a Q8.8 weight
// o_out     out  statistics of one component, last_component on the final one
// APB       in   dims_in_use at byte address 0
//
// In the front a sample passes its lanes one after another, each lane in a
// product phase and a square phase. The back then accumulates and, for each
// component, runs the 4-bit-per-cycle divider and the mean square step.
// A clear request skips the lane phases. Reset is synchronous, active low.
// A stalled o_out holds the back; the two-entry queue lets the front go on.
// ----------------------------------------------------------------------------
module weighted_vector_statistics_core
    import wvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    wvs_in_if.sink      i_in,
    wvs_out_if.source   o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [DIMS_W-1:0] r_dims;
    logic [DIMS_W-1:0] n_dims;
    logic              w_wr;
    t_ctrl             w_ctrl;
    t_status           w_status;
    t_work             w_f_work;
    logic              w_f_valid;
    logic              w_f_ready;
    t_work             w_q_work;
    logic              w_q_valid;
    logic              w_q_ready;

    assign o_pready = 1'b1;
    assign o_prdata = i_paddr[2] ? '0 : {{(32-DIMS_W){1'b0}}, r_dims};
    // ignore writes while samples are held
    assign w_wr = i_psel && i_penable && i_pwrite && !i_paddr[2] && w_status.count_zero;

    always_comb begin
        n_dims = i_pwdata[DIMS_W-1:0];
        if (n_dims == '0) n_dims = DIMS_W'(1);
        if (n_dims > DIMS_W'(LANES)) n_dims = DIMS_W'(LANES);
    end

    assign w_ctrl.cfg_clear = w_wr;
    assign w_ctrl.dims      = r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(1);
        end else if (w_wr) begin
            r_dims <= n_dims;
        end
    end

    wvs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_work       (w_f_work),
        .o_work_valid (w_f_valid),
        .i_work_ready (w_f_ready)
    );

    wvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (w_f_work),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_work  (w_q_work),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready)
    );

    wvs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .o_status     (w_status),
        .i_work       (w_q_work),
        .i_work_valid (w_q_valid),
        .o_work_ready (w_q_ready),
        .o_out        (o_out)
    );

endmodule
